// ----- rtl/ppa_pkg.sv -----
package ppa_pkg;

    localparam int COORD_W  = 24;
    localparam int BASIS_W  = 16;
    localparam int PROD_W   = COORD_W + BASIS_W;
    localparam int DOT_W    = PROD_W + 2;
    localparam int FRAC_SH  = 15;
    localparam int POINT_W  = 26;
    localparam int CROSS_W  = 2 * POINT_W;
    localparam int SUM_W    = 64;
    localparam int AREA_W   = 63;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS = 6;

    localparam logic [DOT_W-1:0] ROUND_HALF = DOT_W'(1) << (FRAC_SH - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_U_X = 3'd0,
        REG_U_Y = 3'd1,
        REG_U_Z = 3'd2,
        REG_V_X = 3'd3,
        REG_V_Y = 3'd4,
        REG_V_Z = 3'd5
    } cfg_reg_t;

    typedef logic signed [POINT_W-1:0] point_t;

    typedef struct packed {
        point_t px;
        point_t py;
        logic   last;
    } proj_t;

endpackage

// ----- rtl/ppa_front.sv -----
module ppa_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,    // vertex_x, vertex_y, vertex_z
    input  logic                          s_tlast,    // last_vertex
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppa_pkg::BASIS_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ppa_pkg::proj_t                out_data
);
    import ppa_pkg::*;

    logic signed [BASIS_W-1:0] basis_reg [NUM_REGS];
    logic signed [COORD_W-1:0] vx, vy, vz;

    logic                      v1_reg, v2_reg;
    logic                      last1_reg;
    logic signed [PROD_W-1:0]  prod_reg [NUM_REGS];
    logic signed [PROD_W-1:0]  prod_next [NUM_REGS];
    proj_t                     proj_reg;
    proj_t                     proj_next;
    logic [DOT_W-1:0]          dot_u, dot_v;
    logic                      adv1, adv2;

    assign vx = signed'(s_tdata[COORD_W-1:0]);
    assign vy = signed'(s_tdata[2*COORD_W-1:COORD_W]);
    assign vz = signed'(s_tdata[3*COORD_W-1:2*COORD_W]);

    assign adv2      = !v2_reg || out_ready;
    assign adv1      = !v1_reg || adv2;
    assign s_tready  = adv1;
    assign cfg_ready = 1'b1;
    assign out_valid = v2_reg;
    assign out_data  = proj_reg;

    always_comb begin
        prod_next[0] = PROD_W'(basis_reg[0]) * PROD_W'(vx);
        prod_next[1] = PROD_W'(basis_reg[1]) * PROD_W'(vy);
        prod_next[2] = PROD_W'(basis_reg[2]) * PROD_W'(vz);
        prod_next[3] = PROD_W'(basis_reg[3]) * PROD_W'(vx);
        prod_next[4] = PROD_W'(basis_reg[4]) * PROD_W'(vy);
        prod_next[5] = PROD_W'(basis_reg[5]) * PROD_W'(vz);
    end

    // round half up from Q.23 to Q.8 by taking the floor after adding half
    always_comb begin
        dot_u = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]) + ROUND_HALF;
        dot_v = DOT_W'(prod_reg[3]) + DOT_W'(prod_reg[4]) + DOT_W'(prod_reg[5]) + ROUND_HALF;
        proj_next.px   = dot_u[FRAC_SH +: POINT_W];
        proj_next.py   = dot_v[FRAC_SH +: POINT_W];
        proj_next.last = last1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            basis_reg[REG_U_X] <= 16'sd32767;
            basis_reg[REG_U_Y] <= '0;
            basis_reg[REG_U_Z] <= '0;
            basis_reg[REG_V_X] <= '0;
            basis_reg[REG_V_Y] <= 16'sd32767;
            basis_reg[REG_V_Z] <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_U_X: basis_reg[REG_U_X] <= signed'(cfg_data);
                    REG_U_Y: basis_reg[REG_U_Y] <= signed'(cfg_data);
                    REG_U_Z: basis_reg[REG_U_Z] <= signed'(cfg_data);
                    REG_V_X: basis_reg[REG_V_X] <= signed'(cfg_data);
                    REG_V_Y: basis_reg[REG_V_Y] <= signed'(cfg_data);
                    REG_V_Z: basis_reg[REG_V_Z] <= signed'(cfg_data);
                    default: ;
                endcase
            end
            if (adv1) begin
                v1_reg <= s_tvalid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            prod_reg  <= prod_next;
            last1_reg <= s_tlast;
        end
        if (adv2) begin
            proj_reg <= proj_next;
        end
    end

endmodule

// ----- rtl/ppa_fifo.sv -----
module ppa_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ppa_pkg::proj_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output ppa_pkg::proj_t rd_data
);
    import ppa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    proj_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/ppa_back.sv -----
module ppa_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ppa_pkg::proj_t             in_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ppa_pkg::AREA_W-1:0] area
);
    import ppa_pkg::*;

    typedef enum logic {
        ST_RUN,
        ST_CLOSE
    } state_t;

    state_t                     state_reg;
    logic                       awaiting_reg;
    point_t                     first_x_reg, first_y_reg;
    point_t                     prev_x_reg, prev_y_reg;
    logic                       mul_valid_reg, mul_first_reg, mul_close_reg;
    logic signed [CROSS_W-1:0]  prod_a_reg, prod_b_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic                       out_valid_reg;
    logic [AREA_W-1:0]          area_reg;

    logic                       pop, close_ok, issue_close;
    point_t                     ax, ay, bx, by;
    logic [SUM_W-1:0]           sum_next, neg_sum;

    assign in_ready    = state_reg == ST_RUN;
    assign pop         = in_valid && in_ready;
    // the output register must be free by the time a closing term is summed
    assign close_ok    = !out_valid_reg && !(mul_valid_reg && mul_close_reg);
    assign issue_close = (state_reg == ST_CLOSE) && close_ok;

    always_comb begin
        if (state_reg == ST_CLOSE) begin
            ax = prev_x_reg;  ay = prev_y_reg;
            bx = first_x_reg; by = first_y_reg;
        end else if (awaiting_reg) begin
            ax = in_data.px;  ay = in_data.py;
            bx = in_data.px;  by = in_data.py;
        end else begin
            ax = prev_x_reg;  ay = prev_y_reg;
            bx = in_data.px;  by = in_data.py;
        end
    end

    always_comb begin
        sum_next = (mul_first_reg ? '0 : sum_reg) + SUM_W'(prod_a_reg) - SUM_W'(prod_b_reg);
        neg_sum  = SUM_W'(0) - sum_next;
    end

    assign m_tvalid = out_valid_reg;
    assign area     = area_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            awaiting_reg  <= 1'b1;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            mul_valid_reg <= 1'b0;
            mul_first_reg <= 1'b0;
            mul_close_reg <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= pop || issue_close;
            mul_first_reg <= pop && awaiting_reg;
            mul_close_reg <= issue_close;
            if (pop || issue_close) begin
                prod_a_reg <= CROSS_W'(ax) * CROSS_W'(by);
                prod_b_reg <= CROSS_W'(bx) * CROSS_W'(ay);
            end
            case (state_reg)
                ST_RUN: begin
                    if (pop) begin
                        prev_x_reg <= in_data.px;
                        prev_y_reg <= in_data.py;
                        if (awaiting_reg) begin
                            first_x_reg <= in_data.px;
                            first_y_reg <= in_data.py;
                        end
                        awaiting_reg <= in_data.last;
                        state_reg    <= in_data.last ? ST_CLOSE : ST_RUN;
                    end
                end
                ST_CLOSE: begin
                    if (close_ok) begin
                        state_reg <= ST_RUN;
                    end
                end
                default: state_reg <= ST_RUN;
            endcase
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (mul_valid_reg) begin
                sum_reg <= sum_next;
                if (mul_close_reg) begin
                    area_reg      <= neg_sum[AREA_W-1:0];
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/projected_polygon_area.sv -----
// m_tvalid rises with the area after the last vertex passes the front product and
// projection registers, the queue, the back-end product registers and the closing term.
// Throughput: one vertex per cycle when nothing stalls, plus a closing term per polygon;
// a closing term waits for the single area register to empty, and m_tready stalls back
// up through the queue to s_tready. Reset: synchronous, active low; basis registers
// return to u = x, v = y and the next vertex starts a new polygon.
module projected_polygon_area #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,    // vertex_x, vertex_y, vertex_z
    input  logic                          s_tlast,    // last_vertex
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,    // signed_area, zero pad
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppa_pkg::BASIS_W-1:0]   cfg_data
);
    import ppa_pkg::*;

    logic              f_valid, f_ready;
    proj_t             f_data;
    logic              q_valid, q_ready;
    proj_t             q_data;
    logic [AREA_W-1:0] area;

    ppa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    ppa_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    ppa_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .area     (area)
    );

    assign m_tdata = {1'b0, area};

endmodule
